// File: rtl/core/sbt_pkg.sv
`timescale 1ns / 1ps

package sbt_pkg;

  localparam int HISTORY_DEPTH_DEF = 64;
  localparam int PRICE_W = 32;
  localparam int WIN_W = 6;
  localparam int SUM_W = 38;
  localparam int CNT_W = 7;
  localparam int PROD_W = SUM_W + WIN_W;
  localparam int PROFIT_W = 48;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SHORT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRENGTH = 2'd2;

  localparam logic [WIN_W-1:0] SHORT_RESET = 6'd5;
  localparam logic [WIN_W-1:0] LONG_RESET = 6'd20;
  localparam logic [WIN_W-1:0] STRENGTH_RESET = 6'd14;

  typedef struct packed {
    logic [PRICE_W-1:0] close_price;
  } candle_t;

  typedef struct packed {
    logic                       holding;
    logic                       entered;
    logic                       exited;
    logic signed [PROFIT_W-1:0] total_profit;
    logic                       enough_data;
    logic                       profit_saturated;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [WIN_W-1:0]     value;
  } cfg_t;

  typedef struct packed {
    logic [WIN_W-1:0] short_n;
    logic [WIN_W-1:0] long_n;
    logic [WIN_W-1:0] strength_n;
  } win_t;

  // taps picked out of the history row for the words leaving each window
  typedef struct packed {
    logic [PRICE_W-1:0] short_out;
    logic [PRICE_W-1:0] long_out;
    logic [PRICE_W-1:0] chg_cur;
    logic [PRICE_W-1:0] chg_prev;
  } taps_t;

  typedef struct packed {
    logic push;
    logic rotate;
  } row_ctrl_t;

  typedef struct packed {
    logic [SUM_W-1:0] short_sum;
    logic [SUM_W-1:0] long_sum;
    logic [SUM_W-1:0] rise_sum;
    logic [SUM_W-1:0] fall_sum;
  } sums_t;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic               sfull;
    logic               lfull;
    logic               svalid;
    logic               enough;
  } stage_t;

endpackage

// File: rtl/core/sbt_stream_if.sv
`timescale 1ns / 1ps

interface sbt_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/sma_crossover_rsi_backtest.sv
// Throughput: one candle word per cycle while the result is taken and no register write
//   or reload is pending; each word shifts the history row once and moves every window
//   sum by one entering and one leaving tap. The result word is registered in st1, the
//   trade stage and the output register. A register write reloads the window sums by
//   rotating the history row once around, with candle.ready and cfg.ready held low.
// Reset (rst, synchronous, active high) restores default windows, clears history and trade state.
`timescale 1ns / 1ps

module sma_crossover_rsi_backtest #(
  parameter int HISTORY_DEPTH = sbt_pkg::HISTORY_DEPTH_DEF
) (
  input logic          clk,
  input logic          rst,
  sbt_stream_if.sink   candle,
  sbt_stream_if.source result,
  sbt_stream_if.sink   cfg
);

  localparam int PW = sbt_pkg::PRICE_W;
  localparam int CW = sbt_pkg::CNT_W;
  localparam int SW = sbt_pkg::SUM_W;
  localparam int RBW = $clog2(HISTORY_DEPTH);

  sbt_pkg::win_t      win;
  sbt_pkg::sums_t     sums, sums_next;
  logic [CW-1:0]      items_seen, avail_next;
  logic               rebuilding;
  logic [RBW-1:0]     rb_cnt;
  logic               st1_valid;
  sbt_pkg::stage_t    st1;
  sbt_pkg::row_ctrl_t row_ctrl;
  sbt_pkg::taps_t     taps;
  logic [PW-1:0]      price, head, second;
  logic               advance, accept, cfg_write;
  logic               drop_short, drop_long, drop_chg;
  logic               rb_short, rb_long, rb_chg;
  logic               full_short, full_long, str_valid, enough;
  int                 max_win;

  assign price = candle.data.close_price;
  assign advance = !result.valid || result.ready;
  // a pending register write takes the cycle, the candle waits
  assign candle.ready = advance && !rebuilding && !cfg.valid;
  assign cfg.ready = !rebuilding;
  assign accept = candle.valid && candle.ready;
  assign cfg_write = cfg.valid && cfg.ready;

  assign row_ctrl.push = accept;
  assign row_ctrl.rotate = rebuilding;

  sbt_row #(.DEPTH(HISTORY_DEPTH)) u_row (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (row_ctrl),
    .win       (win),
    .new_price (price),
    .head      (head),
    .second    (second),
    .taps      (taps)
  );

  always_comb begin
    drop_short = int'(items_seen) >= int'(win.short_n);
    drop_long = int'(items_seen) >= int'(win.long_n);
    drop_chg = int'(items_seen) >= int'(win.strength_n) + 1;
    rb_short = int'(rb_cnt) < int'(win.short_n) && int'(rb_cnt) < int'(items_seen);
    rb_long = int'(rb_cnt) < int'(win.long_n) && int'(rb_cnt) < int'(items_seen);
    rb_chg = int'(rb_cnt) < int'(win.strength_n) && int'(rb_cnt) + 1 < int'(items_seen);

    avail_next = (items_seen == '1) ? items_seen : items_seen + 1'b1;
    full_short = win.short_n != '0 && int'(win.short_n) <= int'(avail_next) &&
                 int'(win.short_n) <= HISTORY_DEPTH;
    full_long = win.long_n != '0 && int'(win.long_n) <= int'(avail_next) &&
                int'(win.long_n) <= HISTORY_DEPTH;
    str_valid = win.strength_n != '0 && int'(win.strength_n) + 1 <= int'(avail_next) &&
                int'(win.strength_n) + 1 <= HISTORY_DEPTH;
    max_win = (win.long_n > win.strength_n) ? int'(win.long_n) : int'(win.strength_n);
    enough = int'(items_seen) > max_win;
  end

  always_comb begin
    sums_next = sums;
    if (cfg_write) begin
      // clear the sums, the rotation pass fills them again
      sums_next = '0;
    end else if (rebuilding) begin
      // head walks through the history, second is the close before it
      if (rb_short) sums_next.short_sum = sums.short_sum + SW'(head);
      if (rb_long) sums_next.long_sum = sums.long_sum + SW'(head);
      if (rb_chg) begin
        if (head > second) begin
          sums_next.rise_sum = sums.rise_sum + SW'(head - second);
        end else begin
          sums_next.fall_sum = sums.fall_sum + SW'(second - head);
        end
      end
    end else if (accept) begin
      sums_next.short_sum = sums.short_sum + SW'(price) -
                            (drop_short ? SW'(taps.short_out) : '0);
      sums_next.long_sum = sums.long_sum + SW'(price) -
                           (drop_long ? SW'(taps.long_out) : '0);
      if (items_seen != '0) begin
        if (price > head) begin
          sums_next.rise_sum = sums_next.rise_sum + SW'(price - head);
        end else begin
          sums_next.fall_sum = sums_next.fall_sum + SW'(head - price);
        end
      end
      // drop the oldest change once the strength window is full
      if (drop_chg) begin
        if (taps.chg_cur > taps.chg_prev) begin
          sums_next.rise_sum = sums_next.rise_sum - SW'(taps.chg_cur - taps.chg_prev);
        end else begin
          sums_next.fall_sum = sums_next.fall_sum - SW'(taps.chg_prev - taps.chg_cur);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win.short_n <= sbt_pkg::SHORT_RESET;
      win.long_n <= sbt_pkg::LONG_RESET;
      win.strength_n <= sbt_pkg::STRENGTH_RESET;
      sums <= '0;
      items_seen <= '0;
      rebuilding <= 1'b0;
      rb_cnt <= '0;
    end else begin
      sums <= sums_next;
      if (accept && items_seen != '1) items_seen <= items_seen + 1'b1;
      if (cfg_write) begin
        unique case (cfg.data.index)
          sbt_pkg::REG_SHORT: win.short_n <= cfg.data.value;
          sbt_pkg::REG_LONG: win.long_n <= cfg.data.value;
          sbt_pkg::REG_STRENGTH: win.strength_n <= cfg.data.value;
          default: ;
        endcase
        rebuilding <= 1'b1;
        rb_cnt <= '0;
      end else if (rebuilding) begin
        rb_cnt <= rb_cnt + 1'b1;
        if (rb_cnt == RBW'(HISTORY_DEPTH - 1)) rebuilding <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st1_valid <= 1'b0;
    end else if (advance) begin
      st1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st1.price <= price;
      st1.sfull <= full_short;
      st1.lfull <= full_long;
      st1.svalid <= str_valid;
      st1.enough <= enough;
    end
  end

  sbt_trade u_trade (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .st1_valid (st1_valid),
    .st1       (st1),
    .sums      (sums),
    .win       (win),
    .out_valid (result.valid),
    .out_data  (result.data)
  );

`ifndef ASSERT_OFF
  a_cfg_stalls_input: assert property (@(posedge clk) disable iff (rst)
    cfg.valid && cfg.ready |=> !candle.ready)
    else $error("candle taken while window sums reload");

  a_entry_holds: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.data.entered |-> result.data.holding)
    else $error("entry word without open position");

  a_exit_flat: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.data.exited |-> !result.data.holding && !result.data.entered)
    else $error("exit word with position still open");
`endif

endmodule

// File: rtl/core/sbt_cell.sv
`timescale 1ns / 1ps

module sbt_cell #(
  parameter int IDX = 0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  sbt_pkg::row_ctrl_t           ctrl,
  input  sbt_pkg::win_t                win,
  input  logic [sbt_pkg::PRICE_W-1:0]  from_lo,
  input  logic [sbt_pkg::PRICE_W-1:0]  from_hi,
  output logic [sbt_pkg::PRICE_W-1:0]  price,
  output sbt_pkg::taps_t               taps
);

  logic pick_short, pick_long, pick_cur, pick_prev;

  // push moves words toward older slots, rotate walks the row around once
  always_ff @(posedge clk) begin
    if (rst) begin
      price <= '0;
    end else if (ctrl.push) begin
      price <= from_lo;
    end else if (ctrl.rotate) begin
      price <= from_hi;
    end
  end

  always_comb begin
    pick_short = int'(win.short_n) == IDX + 1;
    pick_long = int'(win.long_n) == IDX + 1;
    pick_cur = int'(win.strength_n) == IDX + 1;
    pick_prev = int'(win.strength_n) == IDX;
    taps.short_out = pick_short ? price : '0;
    taps.long_out = pick_long ? price : '0;
    taps.chg_cur = pick_cur ? price : '0;
    taps.chg_prev = pick_prev ? price : '0;
  end

endmodule

// File: rtl/core/sbt_row.sv
`timescale 1ns / 1ps

module sbt_row #(
  parameter int DEPTH = sbt_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  sbt_pkg::row_ctrl_t           ctrl,
  input  sbt_pkg::win_t                win,
  input  logic [sbt_pkg::PRICE_W-1:0]  new_price,
  output logic [sbt_pkg::PRICE_W-1:0]  head,
  output logic [sbt_pkg::PRICE_W-1:0]  second,
  output sbt_pkg::taps_t               taps
);

  logic [sbt_pkg::PRICE_W-1:0] cell_price [DEPTH];
  sbt_pkg::taps_t              cell_taps [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [sbt_pkg::PRICE_W-1:0] lo, hi;

    if (k == 0) begin : g_first
      assign lo = new_price;
    end else begin : g_inner_lo
      assign lo = cell_price[k-1];
    end

    if (k == DEPTH - 1) begin : g_last
      assign hi = cell_price[0];
    end else begin : g_inner_hi
      assign hi = cell_price[k+1];
    end

    sbt_cell #(.IDX(k)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .win     (win),
      .from_lo (lo),
      .from_hi (hi),
      .price   (cell_price[k]),
      .taps    (cell_taps[k])
    );
  end

  assign head = cell_price[0];
  assign second = cell_price[1];

  // at most one cell matches each window length
  always_comb begin
    taps = '0;
    for (int k = 0; k < DEPTH; k++) begin
      taps = taps | cell_taps[k];
    end
  end

endmodule

// File: rtl/core/sbt_trade.sv
`timescale 1ns / 1ps

module sbt_trade (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              st1_valid,
  input  sbt_pkg::stage_t   st1,
  input  sbt_pkg::sums_t    sums,
  input  sbt_pkg::win_t     win,
  output logic              out_valid,
  output sbt_pkg::result_t  out_data
);

  localparam int PW = sbt_pkg::PRICE_W;
  localparam int QW = sbt_pkg::PROD_W;
  localparam int FW = sbt_pkg::PROFIT_W;
  localparam int SW = FW + 1;

  logic          v2;
  logic [PW-1:0] price2;
  logic [QW-1:0] prod_s, prod_l;
  logic          sfull2, lfull2, snz2, lnz2, sok2, enough2;

  logic                 in_trade;
  logic [PW-1:0]        entry_level;
  logic signed [FW-1:0] profit_acc;
  logic                 sat_flag;

  logic                 a_side, b_side, gt, lt, enter, leave;
  logic signed [PW:0]   delta;
  logic signed [SW-1:0] trade_sum;
  logic signed [FW-1:0] profit_next;
  logic                 sat_next;

  // cross-multiply the window sums so the averages need no divider
  always_ff @(posedge clk) begin
    if (advance && st1_valid) begin
      price2 <= st1.price;
      prod_s <= QW'(sums.short_sum) * QW'(win.long_n);
      prod_l <= QW'(sums.long_sum) * QW'(win.short_n);
      sfull2 <= st1.sfull;
      lfull2 <= st1.lfull;
      snz2 <= sums.short_sum != '0;
      lnz2 <= sums.long_sum != '0;
      sok2 <= st1.svalid && (sums.fall_sum == '0 || sums.rise_sum > sums.fall_sum);
      enough2 <= st1.enough;
    end
  end

  always_comb begin
    a_side = sfull2 && snz2;
    b_side = lfull2 && lnz2;
    // a window that is not full averages to zero
    if (sfull2 && lfull2) begin
      gt = prod_s > prod_l;
      lt = prod_s < prod_l;
    end else begin
      gt = a_side && !b_side;
      lt = !a_side && b_side;
    end
    enter = v2 && enough2 && !in_trade && gt && sok2;
    leave = v2 && enough2 && in_trade && lt;

    delta = $signed({1'b0, price2}) - $signed({1'b0, entry_level});
    trade_sum = SW'(profit_acc) + SW'(delta);
    profit_next = profit_acc;
    sat_next = sat_flag;
    if (leave) begin
      if (trade_sum[FW] != trade_sum[FW-1]) begin
        sat_next = 1'b1;
        profit_next = trade_sum[FW] ? {1'b1, {(FW-1){1'b0}}} : {1'b0, {(FW-1){1'b1}}};
      end else begin
        profit_next = trade_sum[FW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      out_valid <= 1'b0;
      in_trade <= 1'b0;
      entry_level <= '0;
      profit_acc <= '0;
      sat_flag <= 1'b0;
    end else if (advance) begin
      v2 <= st1_valid;
      out_valid <= v2;
      if (enter) begin
        in_trade <= 1'b1;
        entry_level <= price2;
      end else if (leave) begin
        in_trade <= 1'b0;
      end
      profit_acc <= profit_next;
      sat_flag <= sat_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && v2) begin
      out_data <= '{
        holding: enter | (in_trade & ~leave),
        entered: enter,
        exited: leave,
        total_profit: profit_next,
        enough_data: enough2,
        profit_saturated: sat_next
      };
    end
  end

endmodule
